[hw/rtl/relative_strength_index_unit_assert.svh]
// Assertion macros shared by the relative strength index unit.
`ifndef RELATIVE_STRENGTH_INDEX_UNIT_ASSERT_SVH
`define RELATIVE_STRENGTH_INDEX_UNIT_ASSERT_SVH

// The condition holds in the same cycle as the trigger.
`define RSI_ASSERT_SAME(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// The condition holds in the cycle after the trigger.
`define RSI_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

[hw/rtl/rsi_pkg.sv]
// Shared types and constants of the relative strength index unit.
package rsi_pkg;

  // Width of the RSI result and its fixed values in Q7.8 percent.
  localparam int unsigned RSI_BITS = 15;
  localparam logic [RSI_BITS-1:0] RSI_FULL = 15'd25600;
  localparam logic [RSI_BITS-1:0] RSI_HALF = 15'd12800;

  // Default data widths.
  localparam int unsigned PRICE_BITS_DEF   = 32;
  localparam int unsigned AVERAGE_BITS_DEF = 48;
  localparam int unsigned TIME_BITS        = 32;

  // Configuration registers.
  localparam int unsigned LOOKBACK_W = 8;
  localparam int unsigned CANDLE_W   = 17;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOKBACK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANDLE   = 1'b1;
  localparam logic [LOOKBACK_W-1:0] LOOKBACK_RST = 8'd14;
  localparam logic [LOOKBACK_W-1:0] LOOKBACK_MIN = 8'd2;
  localparam logic [CANDLE_W-1:0]   CANDLE_RST   = 17'd60;

  // Result request: rsi_value, seeded, candle_taken, padded to bytes.
  localparam int unsigned OUT_W = ((RSI_BITS + 2 + 7) / 8) * 8;

  // Command to the shared divider. A short run produces only RSI_BITS
  // quotient bits from a preloaded partial remainder.
  typedef struct packed {
    logic start;
    logic short_run;
  } div_cmd_t;

endpackage

[hw/rtl/rsi_div.sv]
// Shared bit-serial restoring divider of the relative strength index unit.
module rsi_div #(
  parameter int unsigned DW = 56,
  parameter int unsigned VW = 49
) (
  input  logic                clk,
  input  logic                rst,
  input  rsi_pkg::div_cmd_t   cmd,
  input  logic [DW-1:0]       dividend_init,
  input  logic [VW-1:0]       rem_init,
  input  logic [VW-1:0]       divisor,
  output logic                done,
  output logic [DW-1:0]       quotient,
  output logic [VW-1:0]       remainder
);
  import rsi_pkg::*;

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [VW-1:0] rem;
  logic [DW-1:0] dq;
  logic [VW-1:0] dvs;

  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          fits;
  logic [VW-1:0] rem_next;

  // One quotient bit per cycle; the partial remainder always stays below
  // the divisor, so the shifted trial value fits in VW+1 bits.
  always_comb begin
    trial    = {rem, dq[DW-1]};
    diff     = trial - {1'b0, dvs};
    fits     = (trial >= {1'b0, dvs});
    rem_next = fits ? diff[VW-1:0] : trial[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.short_run ? CW'(RSI_BITS) : CW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem <= rem_init;
      dq  <= dividend_init;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      dq  <= {dq[DW-2:0], fits};
    end
  end

  assign quotient  = dq;
  assign remainder = rem;

endmodule

[hw/rtl/relative_strength_index_unit.sv]
// Top level of the relative strength index unit: sequencer and datapath.
//
// Channel   Direction  Handshake            Contents
// s_*       in         s_tvalid / s_tready  sample_time, price
// m_*       out        m_tvalid / m_tready  rsi_value, seeded, candle_taken
// cfg_*     in         cfg_write only       lookback_periods, candle_seconds
//
// One request is worked on at a time; s_tready is high only while idle. A
// non-candle sample or the first candle goes straight to the output, a warm-up
// candle adds to the sums, and seeding and smoothing candles use the shared
// bit-serial divider; a fixed RSI of 50 or 100 skips the RSI division. Reset is
// synchronous and clears the sequencer, averages and configuration but not the
// payload or divider data registers; a stalled output holds the sequencer.
module relative_strength_index_unit #(
  parameter int unsigned PRICE_BITS   = rsi_pkg::PRICE_BITS_DEF,
  parameter int unsigned AVERAGE_BITS = rsi_pkg::AVERAGE_BITS_DEF
) (
  input  logic                                                  clk,
  input  logic                                                  rst,
  // s_tdata fields from bit 0: sample_time (32), price (PRICE_BITS), zero pad.
  input  logic [((rsi_pkg::TIME_BITS + PRICE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic                                                  s_tvalid,
  output logic                                                  s_tready,
  // m_tdata fields from bit 0: rsi_value (15), seeded (1), candle_taken (1).
  output logic [rsi_pkg::OUT_W-1:0]                             m_tdata,
  output logic                                                  m_tvalid,
  input  logic                                                  m_tready,
  input  logic                                                  cfg_write,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]                         cfg_index,
  input  logic [rsi_pkg::CANDLE_W-1:0]                          cfg_data
);
  import rsi_pkg::*;

  `include "relative_strength_index_unit_assert.svh"

  localparam int unsigned PB = PRICE_BITS;
  localparam int unsigned AB = AVERAGE_BITS;
  // Extra fraction bits of the averages over the price.
  localparam int unsigned AE = (AB > PB) ? AB - PB : 0;
  // A warm-up sum holds up to 255 differences.
  localparam int unsigned SW = PB + LOOKBACK_W;
  localparam int unsigned AW = (AB > SW) ? AB : SW;
  // Averages are cut to at most 48 bits before the RSI division.
  localparam int unsigned RS = (AB > 48) ? AB - 48 : 0;
  localparam int unsigned GW = AB - RS;
  localparam int unsigned VW = GW + 1;
  localparam int unsigned PW = GW + RSI_BITS;
  localparam int unsigned XW = (PB + AE > AB) ? PB + AE : AB;
  localparam int unsigned DW = (SW + AE > AB) ? SW + AE : AB;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CALC   = 4'd1;
  localparam logic [3:0] S_SUM    = 4'd2;
  localparam logic [3:0] S_WPREP  = 4'd3;
  localparam logic [3:0] S_DGO    = 4'd4;
  localparam logic [3:0] S_DWAIT  = 4'd5;
  localparam logic [3:0] S_WAPPLY = 4'd6;
  localparam logic [3:0] S_RPREP  = 4'd7;
  localparam logic [3:0] S_RMUL   = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  // Divider jobs.
  localparam logic [1:0] OP_SEED = 2'd0;
  localparam logic [1:0] OP_WILD = 2'd1;
  localparam logic [1:0] OP_RSI  = 2'd2;

  logic [3:0]            state;
  logic [1:0]            op;
  logic                  sel_loss;

  logic [LOOKBACK_W-1:0] lookback;
  logic [CANDLE_W-1:0]   candle;

  logic [TIME_BITS-1:0]  next_time;
  logic [PB-1:0]         prior_price;
  logic [LOOKBACK_W-1:0] warm_cnt;
  logic [AW-1:0]         gain;
  logic [AW-1:0]         loss;
  logic                  seeded_flag;
  logic [RSI_BITS-1:0]   rsi_reg;
  logic                  candle_hit;

  logic [TIME_BITS-1:0]  smp_time;
  logic [PB-1:0]         smp_price;
  logic [PB-1:0]         up_val;
  logic [PB-1:0]         dn_val;
  logic [XW-1:0]         wdiff;
  logic                  wrise;
  logic [GW-1:0]         gs_reg;
  logic [VW-1:0]         sum_reg;
  logic [PW-1:0]         prod_reg;

  logic [LOOKBACK_W-1:0] eff_n;
  logic [AW-1:0]         cur_avg;
  logic [AB-1:0]         avg_ab;
  logic [PB:0]           price_diff;
  logic [PB-1:0]         cur_x;
  logic [XW-1:0]         xs;
  logic [XW-1:0]         avg_x;
  logic [AB-1:0]         avg_new;
  logic [AB-1:0]         g_ab;
  logic [AB-1:0]         l_ab;
  logic [GW-1:0]         gs;
  logic [GW-1:0]         ls;

  div_cmd_t              div_cmd;
  logic [DW-1:0]         div_dividend;
  logic [VW-1:0]         div_rem_init;
  logic [VW-1:0]         div_divisor;
  logic                  div_done;
  logic [DW-1:0]         div_quot;
  logic [VW-1:0]         div_rem;

  assign s_tready = (state == S_IDLE);

  // Lookback values below two act as two.
  assign eff_n = (lookback < LOOKBACK_MIN) ? LOOKBACK_MIN : lookback;

  // The average being worked on: gain first, then loss.
  assign cur_avg = sel_loss ? loss : gain;
  assign avg_ab  = cur_avg[AB-1:0];
  assign cur_x   = sel_loss ? dn_val : up_val;

  // Price movement against the previous close; the borrow tells the sign.
  assign price_diff = {1'b0, smp_price} - {1'b0, prior_price};

  // Wilder smoothing works on the gap between the scaled new move and the
  // average, so only a division by N is needed.
  assign xs    = XW'(cur_x) << AE;
  assign avg_x = XW'(avg_ab);
  assign avg_new = wrise ? avg_ab + div_quot[AB-1:0]
                         : avg_ab - (div_quot[AB-1:0] + AB'(div_rem != '0));

  assign g_ab = gain[AB-1:0];
  assign l_ab = loss[AB-1:0];
  assign gs   = GW'(g_ab >> RS);
  assign ls   = GW'(l_ab >> RS);

  // Operand selection for the shared divider.
  always_comb begin
    div_cmd.start     = (state == S_DGO);
    div_cmd.short_run = 1'b0;
    div_dividend      = '0;
    div_rem_init      = '0;
    div_divisor       = VW'(eff_n);
    case (op)
      OP_SEED: begin
        // Seeding divides the sum of differences, scaled to average units.
        div_dividend = DW'(cur_avg[SW-1:0]) << AE;
      end
      OP_WILD: begin
        div_dividend = DW'(wdiff);
      end
      OP_RSI: begin
        // The quotient is at most 25600, so the upper product bits can be
        // preloaded as the partial remainder and only RSI_BITS steps run.
        div_cmd.short_run = 1'b1;
        div_dividend      = DW'(prod_reg[RSI_BITS-1:0]) << (DW - RSI_BITS);
        div_rem_init      = VW'(prod_reg >> RSI_BITS);
        div_divisor       = sum_reg;
      end
      default: begin
        div_dividend = '0;
      end
    endcase
  end

  rsi_div #(
    .DW (DW),
    .VW (VW)
  ) u_div (
    .clk           (clk),
    .rst           (rst),
    .cmd           (div_cmd),
    .dividend_init (div_dividend),
    .rem_init      (div_rem_init),
    .divisor       (div_divisor),
    .done          (div_done),
    .quotient      (div_quot),
    .remainder     (div_rem)
  );

  // Configuration registers; the user must write them only while the unit is idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      lookback <= LOOKBACK_RST;
      candle   <= CANDLE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LOOKBACK: lookback <= cfg_data[LOOKBACK_W-1:0];
        CFG_CANDLE:   candle   <= cfg_data;
        default:      lookback <= lookback;
      endcase
    end
  end

  // Sequencer and the state that survives between requests.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      op          <= OP_SEED;
      sel_loss    <= 1'b0;
      next_time   <= '0;
      prior_price <= '0;
      warm_cnt    <= '0;
      gain        <= '0;
      loss        <= '0;
      seeded_flag <= 1'b0;
      rsi_reg     <= '0;
      candle_hit  <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      // In the output state the new result decides m_tvalid on its own.
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          // A candle closes only when the sample time passes the next
          // candle time; a late sample still advances by one candle.
          if (smp_time > next_time) begin
            candle_hit  <= 1'b1;
            next_time   <= next_time + TIME_BITS'(candle);
            prior_price <= smp_price;
            sel_loss    <= 1'b0;
            if (seeded_flag) begin
              state <= S_WPREP;
            end else if (warm_cnt == '0) begin
              // The first candle only loads the previous price.
              gain     <= '0;
              loss     <= '0;
              warm_cnt <= LOOKBACK_W'(1);
              state    <= S_OUT;
            end else begin
              state <= S_SUM;
            end
          end else begin
            candle_hit <= 1'b0;
            state      <= S_OUT;
          end
        end
        S_SUM: begin
          gain <= gain + AW'(up_val);
          loss <= loss + AW'(dn_val);
          if (warm_cnt >= eff_n) begin
            op    <= OP_SEED;
            state <= S_DGO;
          end else begin
            warm_cnt <= warm_cnt + 1'b1;
            rsi_reg  <= '0;
            state    <= S_OUT;
          end
        end
        S_WPREP: begin
          op    <= OP_WILD;
          state <= S_DGO;
        end
        S_DGO: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            case (op)
              OP_SEED: begin
                if (sel_loss) begin
                  loss        <= AW'(div_quot[AB-1:0]);
                  seeded_flag <= 1'b1;
                  warm_cnt    <= '0;
                  state       <= S_RPREP;
                end else begin
                  gain     <= AW'(div_quot[AB-1:0]);
                  sel_loss <= 1'b1;
                  state    <= S_DGO;
                end
              end
              OP_WILD: begin
                state <= S_WAPPLY;
              end
              OP_RSI: begin
                rsi_reg <= div_quot[RSI_BITS-1:0];
                state   <= S_OUT;
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_WAPPLY: begin
          if (sel_loss) begin
            loss  <= AW'(avg_new);
            state <= S_RPREP;
          end else begin
            gain     <= AW'(avg_new);
            sel_loss <= 1'b1;
            state    <= S_WPREP;
          end
        end
        S_RPREP: begin
          // Both averages zero reads as 50, no loss at all as 100.
          if ((g_ab == '0) && (l_ab == '0)) begin
            rsi_reg <= RSI_HALF;
            state   <= S_OUT;
          end else if (l_ab == '0) begin
            rsi_reg <= RSI_FULL;
            state   <= S_OUT;
          end else begin
            state <= S_RMUL;
          end
        end
        S_RMUL: begin
          if (sum_reg == '0) begin
            rsi_reg <= RSI_HALF;
            state   <= S_OUT;
          end else begin
            op    <= OP_RSI;
            state <= S_DGO;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      smp_time  <= s_tdata[TIME_BITS-1:0];
      smp_price <= s_tdata[TIME_BITS+PB-1:TIME_BITS];
    end
    if (state == S_CALC) begin
      up_val <= price_diff[PB] ? '0 : price_diff[PB-1:0];
      dn_val <= price_diff[PB] ? PB'(0) - price_diff[PB-1:0] : '0;
    end
    if (state == S_WPREP) begin
      wrise <= (xs >= avg_x);
      wdiff <= (xs >= avg_x) ? xs - avg_x : avg_x - xs;
    end
    if (state == S_RPREP) begin
      gs_reg  <= gs;
      sum_reg <= VW'(gs) + VW'(ls);
    end
    if (state == S_RMUL) begin
      // 25600 = 2^14 + 2^13 + 2^10.
      prod_reg <= (PW'(gs_reg) << 14) + (PW'(gs_reg) << 13) + (PW'(gs_reg) << 10);
    end
    if ((state == S_OUT) && (!m_tvalid || m_tready)) begin
      m_tdata <= OUT_W'({candle_hit, seeded_flag, rsi_reg});
    end
  end

  // The unit is busy after it takes a request.
  `RSI_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "ready right after a request")
  // The held RSI never exceeds 100 percent.
  `RSI_ASSERT_SAME(a_rsi_range, 1'b1, rsi_reg <= RSI_FULL, "RSI register above 100 percent")
  // Before seeding the reported RSI is zero.
  `RSI_ASSERT_SAME(a_unseeded_zero, m_tvalid && !m_tdata[RSI_BITS], m_tdata[RSI_BITS-1:0] == '0, "nonzero RSI before seeding")
  // The divider only finishes while the sequencer waits for it.
  `RSI_ASSERT_SAME(a_div_done_wait, div_done, state == S_DWAIT, "divider finished outside its wait state")

endmodule
